// ===== src/min_tracking_stack_defines.svh =====
// Assertion macros shared by the checking code of the min tracking stack.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_tracking_stack: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_tracking_stack: next-cycle check failed");

`endif

// ===== src/mts_pkg.sv =====
package mts_pkg;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_QUERY = 2'd0;
    localparam opcode_t OP_PUSH  = 2'd1;
    localparam opcode_t OP_POP   = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    // Commands from the controller to the datapath and the result buffer.
    typedef struct packed {
        logic accept;   // a transaction is taken this cycle
        logic load;     // refill the top registers from the memory read
        logic emit;     // a result is complete this cycle
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_fetch;   // the offered pop uncovers an entry held in memory
    } dp_status_t;

endpackage

// ===== src/mts_ctrl.sv =====
module mts_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mts_pkg::dp_status_t    dp_status,
    input  logic                   buf_space,
    output mts_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && buf_space;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    if (dp_status.need_fetch)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.load   = 1'b1;
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/mts_datapath.sv =====
module mts_datapath
#(
    parameter int STACK_DEPTH = 256,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int CW = $clog2(STACK_DEPTH + 1),
    localparam int RES_W = 66 + CW
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mts_pkg::ctrl_cmd_t        cmd,
    input  mts_pkg::opcode_t          opcode,
    input  logic signed [31:0]        push_value,
    output mts_pkg::dp_status_t       dp_status,
    output logic [RES_W-1:0]          res_data
);

    // Entries hold {running minimum, value}.
    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] rd_data_reg;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] top_value_reg;
    logic signed [31:0] top_value_next;
    logic signed [31:0] top_min_reg;
    logic signed [31:0] top_min_next;

    logic               full;
    logic               empty;
    logic signed [31:0] push_min;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    mts_pkg::status_t   res_status;
    logic signed [31:0] res_top;
    logic signed [31:0] res_min;

    assign full  = (count_reg == CW'(STACK_DEPTH));
    assign empty = (count_reg == '0);

    // The top registers always mirror the topmost entry, so its minimum is at hand.
    assign push_min = (!empty && (top_min_reg < push_value)) ? top_min_reg : push_value;

    assign dp_status.need_fetch = (opcode == mts_pkg::OP_POP) && (count_reg > CW'(1));

    assign wr_addr = count_reg[AW-1:0];
    assign rd_addr = AW'(count_reg - CW'(2));

    always_comb
    begin
        count_next     = count_reg;
        top_value_next = top_value_reg;
        top_min_next   = top_min_reg;
        res_status     = mts_pkg::ST_OK;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        if (cmd.load)
        begin
            top_value_next = rd_data_reg[31:0];
            top_min_next   = rd_data_reg[63:32];
        end
        else if (cmd.accept)
        begin
            unique case (opcode)
                mts_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        res_status = mts_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        top_value_next = push_value;
                        top_min_next   = push_min;
                        count_next     = count_reg + CW'(1);
                    end
                end
                mts_pkg::OP_POP:
                begin
                    if (empty)
                    begin
                        res_status = mts_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        rd_en      = dp_status.need_fetch;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_top  = (count_next == '0) ? 32'sd0 : top_value_next;
    assign res_min  = (count_next == '0) ? mts_pkg::INT_MAX : top_min_next;
    assign res_data = {res_status, count_next, res_min, res_top};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_value_reg <= top_value_next;
        top_min_reg   <= top_min_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {push_min, push_value};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== src/mts_out_buf.sv =====
module mts_out_buf
#(
    parameter int DATA_W = 75
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] data_in,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              out_free;

    // A new result is always accepted while the skid entry is empty.
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= data_in;
            end
            else
            begin
                out_data_reg <= data_in;
            end
        end
        else if (push)
        begin
            skid_data_reg <= data_in;
        end
    end

endmodule

// ===== src/min_tracking_stack.sv =====
// Bounded LIFO stack of signed 32-bit values that also reports the minimum of all
// values held. Each transaction on the input carries an opcode in tuser (query, push,
// pop; the unused code acts as a query) and the value to push in tdata, and yields
// exactly one result: top value, minimum, fill count and status (ok, push refused
// because full, pop refused because empty). An empty stack reports top 0 and minimum
// 2147483647. A query, a push, a refused operation or a pop that empties the stack
// completes in the cycle it is accepted; a pop that leaves entries behind passes
// through a fetch state, because the new top entry comes back through the
// registered read port of the entry memory. Results are registered in a two-entry
// output buffer that lets the next transaction enter while one result still waits.
module min_tracking_stack
#(
    parameter int STACK_DEPTH = 256,
    localparam int CW = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W = ((64 + CW + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // push_value
    input  logic [1:0]       s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // top_value, min_value, fill_count, zero pad
    output logic [1:0]       m_axis_tuser    // status
);

    localparam int RES_W = 66 + CW;

    mts_pkg::ctrl_cmd_t  cmd;
    mts_pkg::dp_status_t dp_status;
    logic                buf_space;
    logic [RES_W-1:0]    res_data;
    logic [RES_W-1:0]    buf_data;

    mts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .dp_status (dp_status),
        .buf_space (buf_space),
        .cmd       (cmd)
    );

    mts_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (s_axis_tuser),
        .push_value (s_axis_tdata),
        .dp_status  (dp_status),
        .res_data   (res_data)
    );

    mts_out_buf #(.DATA_W(RES_W)) u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd.emit),
        .data_in   (res_data),
        .space     (buf_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (buf_data)
    );

    assign m_axis_tdata = OUT_W'(buf_data[63+CW:0]);
    assign m_axis_tuser = buf_data[RES_W-1 -: 2];

endmodule

// ===== src/mts_checker.sv =====
`include "min_tracking_stack_defines.svh"

module mts_checker
#(
    parameter int STACK_DEPTH = 256,
    localparam int CW = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W = ((64 + CW + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [1:0]       m_axis_tuser
);

    logic [CW-1:0]    fill;
    logic             out_stall;
    logic [OUT_W+1:0] out_word;
    logic             full_flag;
    logic             empty_flag;
    logic             empty_out;
    logic             empty_fields;

    assign fill         = m_axis_tdata[63+CW:64];
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_word     = {m_axis_tuser, m_axis_tdata};
    assign full_flag    = m_axis_tvalid && (m_axis_tuser == mts_pkg::ST_FULL);
    assign empty_flag   = m_axis_tvalid && (m_axis_tuser == mts_pkg::ST_EMPTY);
    assign empty_out    = m_axis_tvalid && (fill == '0);
    assign empty_fields = (m_axis_tdata[31:0] == 32'd0)
                          && (m_axis_tdata[63:32] == mts_pkg::INT_MAX);

    // A stalled result must hold its contents.
    `MTS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))

    `MTS_ASSERT_IMPLY(a_fill_bound, m_axis_tvalid, fill <= CW'(STACK_DEPTH))

    `MTS_ASSERT_IMPLY(a_full_refusal, full_flag, fill == CW'(STACK_DEPTH))

    `MTS_ASSERT_IMPLY(a_empty_refusal, empty_flag, fill == '0)

    // An empty stack reports top zero and the largest signed value as minimum.
    `MTS_ASSERT_IMPLY(a_empty_report, empty_out, empty_fields)

endmodule

bind min_tracking_stack mts_checker #(.STACK_DEPTH(STACK_DEPTH)) u_mts_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
